>>> rtl/stb_pkg.sv
package stb_pkg;

  // Q2.14 fixed point
  localparam int FracBits = 14;
  localparam int QOne     = 1 << FracBits;

  // Digits of each rounded square root (result magnitude fits in 15 bits)
  localparam int SqBits = FracBits + 1;

  // Output lanes of the square-root array
  localparam int NumLanes = 5;
  localparam int LanePx   = 0;
  localparam int LanePy   = 1;
  localparam int LanePz   = 2;
  localparam int LaneAx   = 3;
  localparam int LaneAy   = 4;

  // Datapath widths
  localparam int CzW  = 2 * FracBits + 1;  // z^2 after clamp, up to 2^28
  localparam int SqW  = 31;                // x^2 or y^2, up to 2^30
  localparam int DenW = 32;                // x^2 + y^2
  localparam int NumW = CzW + SqW - 1;     // products, up to 2^58
  localparam int ResW = 66;                // signed remainder in the root stages

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] polar_x;
    logic signed [15:0] polar_y;
    logic signed [15:0] polar_z;
    logic signed [15:0] azim_x;
    logic signed [15:0] azim_y;
    logic               z_clamped;
  } out_t;

endpackage

>>> rtl/sphere_tangent_basis.sv
// Spherical-frame tangent vectors of a Q2.14 point: one beat in and one beat
// out per cycle while out_ready_i is high. Stage 1 clamps z and squares x, y,
// z; stage 2 forms the four products, 1 - z^2 and x^2 + y^2; stages 3 to 17
// resolve the five rounded square roots one digit per stage (15 digits);
// stage 18 applies signs and holds the result.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and in_ready_o drops only when every stage is full.
module sphere_tangent_basis (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stb_pkg::out_t out_data_o
);
  import stb_pkg::*;

  localparam int NP   = SqBits + 3;  // total pipeline stages
  localparam int PSq0 = 2;           // first root stage
  localparam int POut = NP - 1;

  logic [NP-1:0] v_q;
  logic [NP-1:0] en;

  // Per-stage advance: a stage loads when it is empty or its beat moves on
  assign en[POut] = !v_q[POut] || out_ready_i;
  for (genvar p = 0; p < POut; p++) begin : g_en
    assign en[p] = !v_q[p] || en[p+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int p = 1; p < NP; p++) begin
        if (en[p]) begin
          v_q[p] <= v_q[p-1];
        end
      end
    end
  end

  // Stage 1: clamp z, squares, pole substitution
  logic signed [15:0] zc;
  logic               clamp_d;
  logic signed [31:0] zsq, xsq, ysq;
  logic               pole;

  logic [CzW-1:0] cz2_q;
  logic [SqW-1:0] x2_q, y2_q;
  logic           cneg_q, xneg_q, yneg_q, clamp1_q;

  always_comb begin
    zc      = in_data_i.vec_z;
    clamp_d = 1'b0;
    if (in_data_i.vec_z > 16'sd16384) begin
      zc      = 16'(QOne);
      clamp_d = 1'b1;
    end else if (in_data_i.vec_z < -16'sd16384) begin
      zc      = -16'(QOne);
      clamp_d = 1'b1;
    end
    zsq  = zc * zc;
    xsq  = in_data_i.vec_x * in_data_i.vec_x;
    ysq  = in_data_i.vec_y * in_data_i.vec_y;
    pole = (in_data_i.vec_x == '0) && (in_data_i.vec_y == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cz2_q    <= zsq[CzW-1:0];
      x2_q     <= pole ? SqW'(1) : xsq[SqW-1:0];
      y2_q     <= pole ? '0 : ysq[SqW-1:0];
      cneg_q   <= zc[15];
      xneg_q   <= in_data_i.vec_x[15];
      yneg_q   <= in_data_i.vec_y[15];
      clamp1_q <= clamp_d;
    end
  end

  // Stage 2: numerators, denominators and result signs per lane
  logic [CzW-1:0]  sz2;
  logic [DenW-1:0] r2;
  logic [59:0]     m_px, m_py, m_ax, m_ay;

  logic [NumW-1:0] num_q [NumLanes];
  logic [DenW-1:0] den_q [NumLanes];
  logic            neg_q [NumLanes];
  logic            clamp2_q;

  always_comb begin
    sz2  = CzW'(1 << (2 * FracBits)) - cz2_q;
    r2   = DenW'(x2_q) + DenW'(y2_q);
    m_px = 60'(cz2_q) * 60'(x2_q);
    m_py = 60'(cz2_q) * 60'(y2_q);
    m_ax = 60'(sz2) * 60'(y2_q);
    m_ay = 60'(sz2) * 60'(x2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      num_q[LanePx] <= m_px[NumW-1:0];
      num_q[LanePy] <= m_py[NumW-1:0];
      num_q[LanePz] <= NumW'(sz2);
      num_q[LaneAx] <= m_ax[NumW-1:0];
      num_q[LaneAy] <= m_ay[NumW-1:0];
      den_q[LanePx] <= r2;
      den_q[LanePy] <= r2;
      den_q[LanePz] <= DenW'(1);
      den_q[LaneAx] <= r2;
      den_q[LaneAy] <= r2;
      neg_q[LanePx] <= cneg_q ^ xneg_q;
      neg_q[LanePy] <= cneg_q ^ yneg_q;
      neg_q[LanePz] <= 1'b1;
      neg_q[LaneAx] <= !yneg_q;
      neg_q[LaneAy] <= xneg_q;
      clamp2_q      <= clamp1_q;
    end
  end

  // Root stages: largest k with (2k-1)^2 * den <= 4 * num, one digit a stage.
  // Tracks rem = 4num - a^2 den and dk = a * den with a = 2k - 1.
  logic signed [ResW-1:0] rem_q [SqBits][NumLanes];
  logic signed [ResW-1:0] dk_q  [SqBits][NumLanes];
  logic [DenW-1:0]        dsr_q [SqBits][NumLanes];
  logic [SqBits-1:0]      k_q   [SqBits][NumLanes];
  logic                   sg_q  [SqBits][NumLanes];
  logic                   cl_q  [SqBits];

  for (genvar s = 0; s < SqBits; s++) begin : g_stage
    localparam int B = SqBits - 1 - s;

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      logic signed [ResW-1:0] rem_in, dk_in, den_x, term, diff;
      logic [DenW-1:0]        den_in;
      logic [SqBits-1:0]      k_in;
      logic                   sg_in;

      // Stage inputs, seeded from the numerator for the first digit
      if (s == 0) begin : g_first
        assign den_in = den_q[l];
        assign den_x  = $signed(ResW'(den_q[l]));
        assign rem_in = $signed({{(ResW-NumW-2){1'b0}}, num_q[l], 2'b00}) - den_x;
        assign dk_in  = -den_x;
        assign k_in   = '0;
        assign sg_in  = neg_q[l];
      end else begin : g_next
        assign den_in = dsr_q[s-1][l];
        assign den_x  = $signed(ResW'(dsr_q[s-1][l]));
        assign rem_in = rem_q[s-1][l];
        assign dk_in  = dk_q[s-1][l];
        assign k_in   = k_q[s-1][l];
        assign sg_in  = sg_q[s-1][l];
      end

      // Trial digit: subtract (2^(b+2) a + 2^(2b+2)) * den
      assign term = (dk_in <<< (B + 2)) + (den_x <<< (2 * B + 2));
      assign diff = rem_in - term;

      always_ff @(posedge clk_i) begin
        if (en[PSq0+s]) begin
          dsr_q[s][l] <= den_in;
          sg_q[s][l]  <= sg_in;
          if (!diff[ResW-1]) begin
            rem_q[s][l] <= diff;
            dk_q[s][l]  <= dk_in + (den_x <<< (B + 1));
            k_q[s][l]   <= k_in | SqBits'(1 << B);
          end else begin
            rem_q[s][l] <= rem_in;
            dk_q[s][l]  <= dk_in;
            k_q[s][l]   <= k_in;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[PSq0+s]) begin
        cl_q[s] <= (s == 0) ? clamp2_q : cl_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Output stage: apply signs
  logic signed [15:0] res [NumLanes];
  out_t               out_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      res[l] = sg_q[SqBits-1][l] ? -$signed(16'(k_q[SqBits-1][l]))
                                 :  $signed(16'(k_q[SqBits-1][l]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[POut]) begin
      out_q.polar_x   <= res[LanePx];
      out_q.polar_y   <= res[LanePy];
      out_q.polar_z   <= res[LanePz];
      out_q.azim_x    <= res[LaneAx];
      out_q.azim_y    <= res[LaneAy];
      out_q.z_clamped <= cl_q[SqBits-1];
    end
  end

  assign out_valid_o = v_q[POut];
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A clamped z lies on a pole of the sphere: sin t is zero
  a_clamp_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.z_clamped |->
      out_data_o.polar_z == '0 && out_data_o.azim_x == '0 && out_data_o.azim_y == '0)
    else $error("clamped z gave nonzero sin t terms");

  // -sin t is never positive
  a_polar_z_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.polar_z[15] || out_data_o.polar_z == '0)
    else $error("polar_z positive");

  // Input backpressure only when the pipe is full to the output
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && v_q[0])
    else $error("input stalled with room in pipeline");
`endif

endmodule
